// ----- src/ffqr_pkg.sv -----
package ffqr_pkg;

    localparam int FLOWS_DEFAULT = 256;

    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;

    typedef enum logic [1:0] {
        VERDICT_ABORT = 2'd0,
        VERDICT_PASS  = 2'd1,
        VERDICT_DROP  = 2'd2
    } verdict_t;

    // one packet word travelling down the flow chain
    typedef struct packed {
        logic        vld;
        verdict_t    kind;
        logic [31:0] key;
        logic [15:0] len;
        logic [63:0] now;
        logic [63:0] rank;
        logic        hit;
        logic        placed;
    } token_t;

endpackage

// ----- src/ffqr_classify.sv -----
module ffqr_classify
    import ffqr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [15:0] frame_len,
    input  logic [15:0] ether_type,
    input  logic [31:0] src_addr,
    input  logic [63:0] now_ns,
    output token_t      tok
);

    token_t   tok_reg;
    token_t   tok_next;
    verdict_t kind;

    always_comb
    begin
        if (frame_len < ETH_HDR_BYTES)
        begin
            kind = VERDICT_ABORT;
        end
        else if (ether_type != ETYPE_IPV4)
        begin
            kind = VERDICT_PASS;
        end
        else if (frame_len < IPV4_MIN_BYTES)
        begin
            kind = VERDICT_ABORT;
        end
        else
        begin
            kind = VERDICT_DROP;
        end

        tok_next.vld    = accept;
        tok_next.kind   = kind;
        tok_next.key    = src_addr;
        tok_next.len    = frame_len;
        tok_next.now    = now_ns;
        tok_next.rank   = now_ns;
        tok_next.hit    = 1'b0;
        tok_next.placed = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

// ----- src/ffqr_cell.sv -----
module ffqr_cell
    import ffqr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tin,
    output token_t tout
);

    token_t      tok_reg;
    token_t      tok_next;
    logic        valid_reg;
    logic        valid_next;
    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [63:0] fin_reg;
    logic [63:0] fin_next;
    logic        is_rank;
    logic        match;
    logic        claim;
    logic [63:0] max_rank;
    logic [63:0] base;
    logic [64:0] sum;
    logic [63:0] sat;

    always_comb
    begin
        tok_next   = tin;
        valid_next = valid_reg;
        key_next   = key_reg;
        fin_next   = fin_reg;

        is_rank  = tin.vld && (tin.kind == VERDICT_DROP);
        match    = is_rank && valid_reg && !tin.hit && (key_reg == tin.key);
        // valid entries form a prefix, so the first free cell lies past every hit
        claim    = is_rank && !valid_reg && !tin.hit && !tin.placed;
        max_rank = (fin_reg > tin.now) ? fin_reg : tin.now;
        base     = match ? max_rank : tin.now;
        sum      = {1'b0, base} + {49'd0, tin.len};
        sat      = sum[64] ? {64{1'b1}} : sum[63:0];

        if (match)
        begin
            tok_next.rank = max_rank;
            tok_next.hit  = 1'b1;
            fin_next      = sat;
        end

        if (claim)
        begin
            valid_next      = 1'b1;
            key_next        = tin.key;
            fin_next        = sat;
            tok_next.placed = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        fin_reg <= fin_next;
    end

    assign tout = tok_reg;

endmodule

// ----- src/flow_fair_queue_rank_top.sv -----
// path to done: the classifier register, each flow cell in turn, then the output register
// throughput: one word per cycle; each flow cell sees a word in the cycle after the last
// busy stays low, the chain of flow cells takes a new word in every cycle
// reset: asynchronous, active low; clears every flow cell's valid bit and the pipeline
// results are shown for one cycle on done; the receiver cannot stall
module flow_fair_queue_rank_top
    import ffqr_pkg::*;
#(
    parameter int FLOWS = FLOWS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] frame_len,
    input  logic [15:0] ether_type,
    input  logic [31:0] src_addr,
    input  logic [63:0] now_ns,
    output logic        done,
    output logic [1:0]  verdict,
    output logic        event_valid,
    output logic [31:0] flow_key,
    output logic [15:0] pkt_length,
    output logic [63:0] arrival_ns,
    output logic [63:0] rank,
    output logic        table_full
);

    // word handed between neighbouring cells, entry 0 from the classifier
    token_t      chain [FLOWS+1];
    token_t      tail;
    logic        accept;
    logic        drop;

    logic        done_reg;
    logic [1:0]  verdict_reg;
    logic        event_valid_reg;
    logic [31:0] flow_key_reg;
    logic [15:0] pkt_length_reg;
    logic [63:0] arrival_ns_reg;
    logic [63:0] rank_reg;
    logic        table_full_reg;

    // every cell updates its entry as the word passes, so a word taken in the
    // cycle after another still sees the update
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // length checks and ethertype, then into the chain
    ffqr_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_len  (frame_len),
        .ether_type (ether_type),
        .src_addr   (src_addr),
        .now_ns     (now_ns),
        .tok        (chain[0])
    );

    // one cell per flow entry; matches and inserts happen in place
    for (genvar g = 0; g < FLOWS; g++)
    begin : g_cell
        ffqr_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .tin   (chain[g]),
            .tout  (chain[g+1])
        );
    end

    assign tail = chain[FLOWS];
    assign drop = tail.vld && (tail.kind == VERDICT_DROP);

    // output register: aborted and passed words carry zero metadata
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            verdict_reg     <= 2'd0;
            event_valid_reg <= 1'b0;
            flow_key_reg    <= '0;
            pkt_length_reg  <= '0;
            arrival_ns_reg  <= '0;
            rank_reg        <= '0;
            table_full_reg  <= 1'b0;
        end
        else
        begin
            done_reg        <= tail.vld;
            verdict_reg     <= tail.vld ? 2'(tail.kind) : 2'd0;
            event_valid_reg <= drop;
            flow_key_reg    <= drop ? tail.key  : 32'd0;
            pkt_length_reg  <= drop ? tail.len  : 16'd0;
            arrival_ns_reg  <= drop ? tail.now  : 64'd0;
            rank_reg        <= drop ? tail.rank : 64'd0;
            // no match and no free cell anywhere along the chain
            table_full_reg  <= drop && !tail.hit && !tail.placed;
        end
    end

    assign done        = done_reg;
    assign verdict     = verdict_reg;
    assign event_valid = event_valid_reg;
    assign flow_key    = flow_key_reg;
    assign pkt_length  = pkt_length_reg;
    assign arrival_ns  = arrival_ns_reg;
    assign rank        = rank_reg;
    assign table_full  = table_full_reg;

    // an event only comes with a ranked drop
    a_event_drop : assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> done && (verdict == 2'(VERDICT_DROP)))
        else $error("event without drop verdict");

    // ranking never moves a packet ahead of its arrival
    a_rank_order : assert property (@(posedge clk) disable iff (!rst_n)
        done && event_valid |-> rank >= arrival_ns)
        else $error("rank below arrival time");

    // a flow left out of a full table is ranked at its arrival
    a_full_rank : assert property (@(posedge clk) disable iff (!rst_n)
        table_full |-> event_valid && (rank == arrival_ns))
        else $error("table full with wrong rank");

    // a ranked word leaving the chain ends up strobed on the next cycle
    a_tail_done : assert property (@(posedge clk) disable iff (!rst_n)
        drop |=> done && event_valid)
        else $error("ranked word lost at output");

endmodule

// ----- verif/ffqr_rank_board_pkg.sv -----
package ffqr_rank_board_pkg;

    import ffqr_pkg::*;

    // what one ranked, passed or aborted word should come back as
    typedef struct packed {
        verdict_t    verdict;
        logic        event_valid;
        logic [31:0] flow_key;
        logic [15:0] pkt_length;
        logic [63:0] arrival_ns;
        logic [63:0] rank;
        logic        table_full;
    } rank_result_t;

    class flow_rank_board;

        // private copy of the flow table
        bit           slot_used   [FLOWS_DEFAULT];
        bit [31:0]    slot_addr   [FLOWS_DEFAULT];
        bit [63:0]    slot_finish [FLOWS_DEFAULT];

        rank_result_t awaited_verdicts[$];
        bit [31:0]    known_flows[$];

        int errors;
        int n_words;
        int n_abort;
        int n_pass;
        int n_ranked;
        int n_hit;
        int n_full;
        int n_sat;

        // work out the result of one accepted word and update the table
        function void note_word(bit [15:0] len, bit [15:0] etype, bit [31:0] addr,
                                bit [63:0] now);
            rank_result_t r;
            int           hit_at;
            int           free_at;
            bit [64:0]    sum;
            r       = '0;
            hit_at  = -1;
            free_at = -1;
            n_words++;
            if (len < ETH_HDR_BYTES) begin
                r.verdict = VERDICT_ABORT;
                n_abort++;
            end
            else if (etype != ETYPE_IPV4) begin
                r.verdict = VERDICT_PASS;
                n_pass++;
            end
            else if (len < IPV4_MIN_BYTES) begin
                r.verdict = VERDICT_ABORT;
                n_abort++;
            end
            else begin
                n_ranked++;
                for (int i = 0; i < FLOWS_DEFAULT; i++) begin
                    if (slot_used[i]) begin
                        if (hit_at < 0 && slot_addr[i] == addr)
                            hit_at = i;
                    end
                    else if (free_at < 0) begin
                        free_at = i;
                    end
                end
                r.verdict     = VERDICT_DROP;
                r.event_valid = 1'b1;
                r.flow_key    = addr;
                r.pkt_length  = len;
                r.arrival_ns  = now;
                if (hit_at >= 0) begin
                    n_hit++;
                    r.rank = (now > slot_finish[hit_at]) ? now : slot_finish[hit_at];
                end
                else begin
                    r.rank = now;
                end
                sum = {1'b0, r.rank} + {49'd0, len};
                if (sum[64])
                    n_sat++;
                if (hit_at >= 0) begin
                    slot_finish[hit_at] = sum[64] ? '1 : sum[63:0];
                end
                else if (free_at >= 0) begin
                    slot_used[free_at]   = 1'b1;
                    slot_addr[free_at]   = addr;
                    slot_finish[free_at] = sum[64] ? '1 : sum[63:0];
                    known_flows.push_back(addr);
                end
                else begin
                    r.table_full = 1'b1;
                    n_full++;
                end
            end
            awaited_verdicts.push_back(r);
        endfunction

        function void match_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one strobed result with the oldest outstanding expectation
        function void check_result(logic [1:0] verdict, logic event_valid,
                                   logic [31:0] flow_key, logic [15:0] pkt_length,
                                   logic [63:0] arrival_ns, logic [63:0] rank,
                                   logic table_full);
            rank_result_t want;
            if (awaited_verdicts.size() == 0) begin
                $error("result strobed with nothing outstanding");
                errors++;
                return;
            end
            want = awaited_verdicts.pop_front();
            match_field("verdict", want.verdict, verdict);
            match_field("event_valid", want.event_valid, event_valid);
            match_field("flow_key", want.flow_key, flow_key);
            match_field("pkt_length", want.pkt_length, pkt_length);
            match_field("arrival_ns", want.arrival_ns, arrival_ns);
            match_field("rank", want.rank, rank);
            match_field("table_full", want.table_full, table_full);
        endfunction

    endclass

endpackage

// ----- verif/tb_flow_fair_queue_rank_top.sv -----
module tb_flow_fair_queue_rank_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ffqr_pkg::*;
    import ffqr_rank_board_pkg::*;

    // three ethertypes that are not ipv4, used in the directed part
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [15:0] ETYPE_SWAPPED = 16'h0008;
    localparam logic [15:0] ETYPE_NEXT    = 16'h0801;
    localparam logic [63:0] TIME_MAX      = '1;
    localparam int          RANDOM_WORDS  = 1400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [63:0] now_ns;
    logic        done;
    logic [1:0]  verdict;
    logic        event_valid;
    logic [31:0] flow_key;
    logic [15:0] pkt_length;
    logic [63:0] arrival_ns;
    logic [63:0] rank;
    logic        table_full;

    flow_rank_board board;

    // sender idling state: when burst_left is non-zero, words go back to back
    int          burst_left;
    // arrival clock, stepped forward at random, for the well-behaved part of the traffic
    logic [63:0] wall_ns;

    flow_fair_queue_rank_top #(
        .FLOWS(FLOWS_DEFAULT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .frame_len  (frame_len),
        .ether_type (ether_type),
        .src_addr   (src_addr),
        .now_ns     (now_ns),
        .done       (done),
        .verdict    (verdict),
        .event_valid(event_valid),
        .flow_key   (flow_key),
        .pkt_length (pkt_length),
        .arrival_ns (arrival_ns),
        .rank       (rank),
        .table_full (table_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // results cannot be held off, so every strobed cycle is checked at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(verdict, event_valid, flow_key, pkt_length,
                               arrival_ns, rank, table_full);
    end

    // offer one word, idle beforehand by a random gap outside a burst, and wait for it to be taken
    task automatic send_word(input logic [15:0] len, input logic [15:0] etype,
                             input logic [31:0] addr, input logic [63:0] now);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 15);
            // now and then, a stretch of back-to-back words
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        frame_len  <= len;
        ether_type <= etype;
        src_addr   <= addr;
        now_ns     <= now;
        // busy read straight after the edge is the value that edge saw
        do
            @(posedge clk);
        while (busy);
        board.note_word(len, etype, addr, now);
    endtask

    // arrival time: mostly a steady clock, with stragglers, wild values and times near the top
    function automatic logic [63:0] pick_time();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            wall_ns = wall_ns + $urandom_range(0, 2000);
            return wall_ns;
        end
        else if (sel < 75)
            return wall_ns - $urandom_range(0, 5000);
        else if (sel < 90)
            return {$urandom(), $urandom()};
        else
            return TIME_MAX - $urandom_range(0, 70000);
    endfunction

    // one random word: mostly well-formed ipv4 frames, the rest short, foreign or runt frames
    task automatic send_random_word();
        int          sel;
        logic [15:0] len;
        logic [15:0] etype;
        logic [31:0] addr;
        sel = $urandom_range(0, 99);
        etype = ETYPE_IPV4;
        addr  = $urandom();
        if (sel < 75)
        begin
            if ($urandom_range(0, 4) == 0)
                len = 16'($urandom_range(IPV4_MIN_BYTES, 16'hFFFF));
            else
                len = 16'($urandom_range(IPV4_MIN_BYTES, 1518));
            // reuse a known flow most of the time so the table sees plenty of hits
            if (board.known_flows.size() > 0 && $urandom_range(0, 99) < 60)
                addr = board.known_flows[$urandom_range(0, board.known_flows.size() - 1)];
        end
        else if (sel < 81)
        begin
            len   = 16'($urandom_range(0, ETH_HDR_BYTES - 1));
            etype = 16'($urandom_range(0, 16'hFFFF));
        end
        else if (sel < 90)
        begin
            len = 16'($urandom_range(ETH_HDR_BYTES, 16'hFFFF));
            do
                etype = 16'($urandom_range(0, 16'hFFFF));
            while (etype == ETYPE_IPV4);
        end
        else
        begin
            len = 16'($urandom_range(ETH_HDR_BYTES, IPV4_MIN_BYTES - 1));
        end
        send_word(len, etype, addr, pick_time());
    endtask

    initial
    begin
        board       = new();
        burst_left  = 0;
        wall_ns     = 64'd1000;
        rst_n       = 1'b0;
        start       = 1'b0;
        frame_len   = '0;
        ether_type  = '0;
        src_addr    = '0;
        now_ns      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boundaries of the frame checks
        send_word(16'd0, ETYPE_IPV4, 32'h0, 64'd0);
        send_word(ETH_HDR_BYTES - 1, 16'hFFFF, 32'hFFFF_FFFF, TIME_MAX);
        send_word(ETH_HDR_BYTES, ETYPE_IPV6, 32'h0A00_0001, 64'd5);
        send_word(ETH_HDR_BYTES, ETYPE_IPV4, 32'h0A00_0001, 64'd6);
        send_word(IPV4_MIN_BYTES - 1, ETYPE_IPV4, 32'h0A00_0001, 64'd7);
        send_word(16'hFFFF, 16'h0000, 32'h0A00_0002, 64'd8);
        send_word(16'd100, ETYPE_NEXT, 32'h0A00_0003, 64'd9);
        send_word(16'd1000, ETYPE_SWAPPED, 32'h0A00_0004, 64'd10);

        // new flow at the smallest legal length, then hits where finish and arrival each win
        send_word(IPV4_MIN_BYTES, ETYPE_IPV4, 32'h0, 64'd0);
        send_word(16'd100, ETYPE_IPV4, 32'h0, 64'd10);
        send_word(16'd1518, ETYPE_IPV4, 32'h0, 64'd1000);
        send_word(16'h8000, ETYPE_IPV4, 32'h0, 64'h8000_0000_0000_0000);

        // finish value saturating at the top of its range
        send_word(16'hFFFF, ETYPE_IPV4, 32'hFFFF_FFFF, TIME_MAX - 64'd10);
        send_word(IPV4_MIN_BYTES, ETYPE_IPV4, 32'hFFFF_FFFF, 64'd5);
        send_word(16'hFFFF, ETYPE_IPV4, 32'h0A00_0001, TIME_MAX);
        send_word(16'd64, ETYPE_IPV4, 32'h0A00_0001, 64'd3);

        // random traffic; fresh flows keep arriving, so the table fills part way through
        repeat (RANDOM_WORDS) send_random_word();
        start <= 1'b0;

        while (board.awaited_verdicts.size() != 0)
            @(posedge clk);
        // let any stray result show itself
        repeat (FLOWS_DEFAULT + 16) @(posedge clk);

        $display("covered %0d words: %0d ranked (%0d flow hits, %0d with a full table)",
                 board.n_words, board.n_ranked, board.n_hit, board.n_full);
        $display("  %0d aborted, %0d passed on, %0d finish values saturated",
                 board.n_abort, board.n_pass, board.n_sat);
        if (board.errors == 0 && board.awaited_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", board.awaited_verdicts.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
